### rtl/core/timer_task_queue_unit_macros.svh
// assertion macros for the timer task queue
`ifndef TIMER_TASK_QUEUE_UNIT_MACROS_SVH
`define TIMER_TASK_QUEUE_UNIT_MACROS_SVH
`define TTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttq check failed");
`define TTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttq check failed");
`endif

### rtl/core/ttq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ttq_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned MaxResults = 16;
  localparam int unsigned TickW = 48;
  localparam int unsigned IdW = 32;
  localparam int unsigned PerW = 32;

  typedef enum logic [2:0] {
    OP_REL = 3'd0, OP_ABS = 3'd1, OP_PER = 3'd2, OP_CANCEL = 3'd3,
    OP_PAUSE = 3'd4, OP_RESUME = 3'd5, OP_CLEAR = 3'd6, OP_TICK = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_ID = 2'd0, KIND_CANCEL = 2'd1, KIND_FIRED = 2'd2, KIND_FULL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SCHED, ST_CANCEL, ST_PICK, ST_FIRE, ST_OUT
  } state_t;

  function automatic logic [TickW-1:0] sat_add(input logic [TickW-1:0] a,
                                               input logic [TickW-1:0] b);
    logic [TickW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TickW] ? {TickW{1'b1}} : s[TickW-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/ttq_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ttq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [47:0] when_value;
  logic [31:0] period;
  logic [31:0] target_id;
  modport source (output valid, op, when_value, period, target_id, input ready);
  modport sink (input valid, op, when_value, period, target_id, output ready);
endinterface

interface ttq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] timer_id;
  logic        found;
  logic        last;
  modport source (output valid, kind, timer_id, found, last, input ready);
  modport sink (input valid, kind, timer_id, found, last, output ready);
endinterface
`default_nettype wire

### rtl/core/timer_task_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// timer task queue: a table of timers ordered by due tick
// in_ carries one request (op, when_value, period, target_id); out_ carries results
// with last set on the final result of each request; pause, resume, clear and a
// paused or empty tick give no result
// one request at a time: in_ready is high only when idle; a result left waiting in
// the output register does not hold off the next request
// pause, resume and clear finish in the accepting cycle
// schedule: the table is scanned one entry a cycle for a free slot, stopping at the
// first one, then the result is loaded in ST_SCHED; cancel checks every entry and
// loads its answer in ST_OUT
// tick: each selection pass scans every entry on one shared compare unit, then fires
// or drops the winner; sixteen fired timers take up to 17 passes, plus one pass per
// cancelled timer dropped
// the result register holds while out_ready is low; the sequencer waits for it
// synchronous active-low reset empties the table, zeroes the tick counter,
// sets the next id to one and clears the pause flag
module timer_task_queue_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ttq_in_if.sink      in_ch,
  ttq_out_if.source   out_ch
);
  localparam int unsigned D = ttq_pkg::QueueDepth;
  localparam int unsigned IW = ttq_pkg::IdxW;
  localparam int unsigned TW = ttq_pkg::TickW;

  ttq_pkg::state_t state_r, state_nxt;

  logic [TW-1:0]              due_r [D];
  logic [ttq_pkg::PerW-1:0]   per_r [D];
  logic [ttq_pkg::IdW-1:0]    id_r [D];
  logic [D-1:0]               val_r, canc_r, hand_r;
  logic [TW-1:0]              now_r;
  logic [ttq_pkg::IdW-1:0]    next_id_r;
  logic                       paused_r;

  ttq_pkg::op_t               op_r;
  logic [TW-1:0]              when_r;
  logic [ttq_pkg::PerW-1:0]   per_in_r;
  logic [ttq_pkg::IdW-1:0]    tgt_r;
  logic [IW-1:0]              idx_r;
  logic                       idx_end;
  logic                       hit_r, found_r;
  logic [IW-1:0]              best_r;
  logic [4:0]                 nfired_r;

  // fired result is marked last once a later pass finds nothing or count ends;
  // so results are held one step: emit the previous pending one when next known
  logic                       pend_r;
  logic [ttq_pkg::IdW-1:0]    pend_id_r;

  logic                       ovalid_r;
  logic [1:0]                 okind_r;
  logic [ttq_pkg::IdW-1:0]    oid_r;
  logic                       ofound_r, olast_r;

  assign in_ch.ready = (state_r == ttq_pkg::ST_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.kind = okind_r;
  assign out_ch.timer_id = oid_r;
  assign out_ch.found = ofound_r;
  assign out_ch.last = olast_r;

  logic in_fire, out_free;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_free = !ovalid_r || out_ch.ready;
  assign idx_end = (idx_r == IW'(D - 1));

  // shared compare: does entry idx beat the current best
  logic cand, better;
  always_comb begin
    cand = val_r[idx_r] && !hand_r[idx_r] && (due_r[idx_r] <= now_r);
    better = !hit_r || (due_r[idx_r] < due_r[best_r]) ||
             ((due_r[idx_r] == due_r[best_r]) && (id_r[idx_r] < id_r[best_r]));
  end

  logic [TW-1:0] sched_due;
  logic [TW-1:0] rel_delay;
  always_comb begin
    rel_delay = (op_r == ttq_pkg::OP_PER && when_r == '0) ? TW'(per_in_r) : when_r;
    sched_due = (op_r == ttq_pkg::OP_ABS) ? when_r : ttq_pkg::sat_add(now_r, rel_delay);
  end

  // tick pass ends when nothing is due or the result count is used up
  logic fire_done, out_load;
  always_comb begin
    fire_done = !hit_r || (!canc_r[best_r] && nfired_r == 5'(ttq_pkg::MaxResults));
    unique case (state_r)
      ttq_pkg::ST_SCHED, ttq_pkg::ST_OUT: out_load = out_free;
      ttq_pkg::ST_FIRE: out_load = out_free && pend_r && (fire_done || !canc_r[best_r]);
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttq_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (ttq_pkg::op_t'(in_ch.op))
            ttq_pkg::OP_REL, ttq_pkg::OP_ABS, ttq_pkg::OP_PER:
              state_nxt = ttq_pkg::ST_SCAN;
            ttq_pkg::OP_CANCEL: state_nxt = ttq_pkg::ST_CANCEL;
            ttq_pkg::OP_TICK: state_nxt = paused_r ? ttq_pkg::ST_IDLE : ttq_pkg::ST_PICK;
            default: state_nxt = ttq_pkg::ST_IDLE;
          endcase
        end
      end
      ttq_pkg::ST_SCAN:
        if (!val_r[idx_r] || idx_end) state_nxt = ttq_pkg::ST_SCHED;
      ttq_pkg::ST_SCHED: if (out_free) state_nxt = ttq_pkg::ST_IDLE;
      ttq_pkg::ST_CANCEL: if (idx_end) state_nxt = ttq_pkg::ST_OUT;
      ttq_pkg::ST_OUT: if (out_free) state_nxt = ttq_pkg::ST_IDLE;
      ttq_pkg::ST_PICK: if (idx_end) state_nxt = ttq_pkg::ST_FIRE;
      ttq_pkg::ST_FIRE: begin
        if (fire_done) begin
          if (!pend_r || out_free) state_nxt = ttq_pkg::ST_IDLE;
        end
        else if (canc_r[best_r]) state_nxt = ttq_pkg::ST_PICK;
        else if (out_free) state_nxt = ttq_pkg::ST_PICK;
      end
      default: state_nxt = ttq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttq_pkg::ST_IDLE;
      val_r <= '0;
      canc_r <= '0;
      hand_r <= '0;
      now_r <= '0;
      next_id_r <= ttq_pkg::IdW'(1);
      paused_r <= 1'b0;
      ovalid_r <= 1'b0;
      pend_r <= 1'b0;
      idx_r <= '0;
      hit_r <= 1'b0;
      found_r <= 1'b0;
      nfired_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        ttq_pkg::ST_IDLE: begin
          if (in_fire) begin
            op_r <= ttq_pkg::op_t'(in_ch.op);
            when_r <= in_ch.when_value;
            per_in_r <= in_ch.period;
            tgt_r <= in_ch.target_id;
            idx_r <= '0;
            hit_r <= 1'b0;
            found_r <= 1'b0;
            hand_r <= '0;
            nfired_r <= '0;
            pend_r <= 1'b0;
            unique case (ttq_pkg::op_t'(in_ch.op))
              ttq_pkg::OP_PAUSE: paused_r <= 1'b1;
              ttq_pkg::OP_RESUME: paused_r <= 1'b0;
              ttq_pkg::OP_CLEAR: begin
                val_r <= '0;
                canc_r <= '0;
              end
              ttq_pkg::OP_TICK: if (!paused_r) now_r <= now_r + TW'(1);
              default: ;
            endcase
          end
        end
        ttq_pkg::ST_SCAN: begin
          if (!val_r[idx_r]) hit_r <= 1'b1;
          else if (!idx_end) idx_r <= idx_r + IW'(1);
        end
        ttq_pkg::ST_SCHED: begin
          if (out_free) begin
            ofound_r <= 1'b0;
            olast_r <= 1'b1;
            if (hit_r) begin
              due_r[idx_r] <= sched_due;
              per_r[idx_r] <= (op_r == ttq_pkg::OP_PER) ? per_in_r : '0;
              id_r[idx_r] <= next_id_r;
              val_r[idx_r] <= 1'b1;
              canc_r[idx_r] <= 1'b0;
              okind_r <= ttq_pkg::KIND_ID;
              oid_r <= next_id_r;
              next_id_r <= next_id_r + ttq_pkg::IdW'(1);
            end else begin
              okind_r <= ttq_pkg::KIND_FULL;
              oid_r <= '0;
            end
          end
        end
        ttq_pkg::ST_CANCEL: begin
          if (val_r[idx_r] && id_r[idx_r] == tgt_r) begin
            canc_r[idx_r] <= 1'b1;
            found_r <= 1'b1;
          end
          if (!idx_end) idx_r <= idx_r + IW'(1);
        end
        ttq_pkg::ST_OUT: begin
          if (out_free) begin
            okind_r <= ttq_pkg::KIND_CANCEL;
            oid_r <= tgt_r;
            ofound_r <= found_r;
            olast_r <= 1'b1;
          end
        end
        ttq_pkg::ST_PICK: begin
          if (cand && better) begin
            hit_r <= 1'b1;
            best_r <= idx_r;
          end
          if (!idx_end) idx_r <= idx_r + IW'(1);
        end
        ttq_pkg::ST_FIRE: begin
          idx_r <= '0;
          if (fire_done) begin
            // pass found nothing more or the count is used up: flush pending as last
            if (pend_r && out_free) begin
              okind_r <= ttq_pkg::KIND_FIRED;
              oid_r <= pend_id_r;
              ofound_r <= 1'b0;
              olast_r <= 1'b1;
              pend_r <= 1'b0;
            end
          end else if (canc_r[best_r]) begin
            val_r[best_r] <= 1'b0;
            canc_r[best_r] <= 1'b0;
            hit_r <= 1'b0;
          end else if (out_free) begin
            hit_r <= 1'b0;
            hand_r[best_r] <= 1'b1;
            nfired_r <= nfired_r + 5'd1;
            if (per_r[best_r] != '0)
              due_r[best_r] <= ttq_pkg::sat_add(now_r, TW'(per_r[best_r]));
            else
              val_r[best_r] <= 1'b0;
            pend_r <= 1'b1;
            pend_id_r <= id_r[best_r];
            if (pend_r) begin
              okind_r <= ttq_pkg::KIND_FIRED;
              oid_r <= pend_id_r;
              ofound_r <= 1'b0;
              olast_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`include "timer_task_queue_unit_macros.svh"
  `TTQ_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, state_r == ttq_pkg::ST_IDLE)
  `TTQ_ASSERT_IMPL(a_fired_cap, clk, rst_n, 1'b1, nfired_r <= 5'(ttq_pkg::MaxResults))
  `TTQ_ASSERT_NEXT(a_pause, clk, rst_n,
                   in_fire && in_ch.op == ttq_pkg::OP_PAUSE, paused_r)
endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import ttq_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandItems = 188;

  typedef struct {
    kind_t       kind;
    logic [31:0] timer_id;
    logic        found;
    logic        last;
  } timer_result_t;

  typedef struct {
    op_t         op;
    logic [47:0] when_value;
    logic [31:0] period;
    logic [31:0] target_id;
    bit          typed;
    kind_t       kind;
    logic [31:0] timer_id;
    logic        found;
  } stim_row_t;

  logic clk;
  logic rst_n;
  ttq_in_if  in_ch();
  ttq_out_if out_ch();

  timer_task_queue_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // own copy of the timer table
  logic [47:0] tm_due [QueueDepth];
  logic [31:0] tm_ivl [QueueDepth];
  logic [31:0] tm_id [QueueDepth];
  bit          tm_vld [QueueDepth];
  bit          tm_cnc [QueueDepth];
  logic [47:0] tm_now;
  logic [31:0] tm_next_id;
  bit          tm_paused;

  timer_result_t pending_results[$];
  bit            failed;
  int unsigned   cycles;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  stim_row_t     cur_row;
  stim_row_t     rows[$];

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  function automatic void push_result(kind_t k, logic [31:0] id, logic f);
    timer_result_t r;
    r.kind = k;
    r.timer_id = id;
    r.found = f;
    r.last = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_row(stim_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_timer(logic [47:0] due, logic [31:0] ivl);
    int slot;
    slot = -1;
    for (int i = 0; i < QueueDepth; i++)
      if (!tm_vld[i] && slot < 0) slot = i;
    if (slot < 0) begin
      push_result(KIND_FULL, '0, 1'b0);
      return;
    end
    tm_due[slot] = due;
    tm_ivl[slot] = ivl;
    tm_id[slot] = tm_next_id;
    tm_vld[slot] = 1'b1;
    tm_cnc[slot] = 1'b0;
    push_result(KIND_ID, tm_next_id, 1'b0);
    tm_next_id = tm_next_id + 32'd1;
  endfunction

  function automatic int advance_tick();
    bit handled [QueueDepth];
    int n;
    int best;
    n = 0;
    if (tm_paused) return 0;
    tm_now = tm_now + 48'd1;
    foreach (handled[i]) handled[i] = 1'b0;
    forever begin
      best = -1;
      for (int i = 0; i < QueueDepth; i++) begin
        if (!tm_vld[i] || handled[i] || tm_due[i] > tm_now) continue;
        if (best < 0 || tm_due[i] < tm_due[best] ||
            (tm_due[i] == tm_due[best] && tm_id[i] < tm_id[best]))
          best = i;
      end
      if (best < 0) break;
      // cancelled timers leave quietly once due
      if (tm_cnc[best]) begin
        tm_vld[best] = 1'b0;
        tm_cnc[best] = 1'b0;
        continue;
      end
      if (n == MaxResults) break;
      handled[best] = 1'b1;
      push_result(KIND_FIRED, tm_id[best], 1'b0);
      n++;
      if (tm_ivl[best] != 0) tm_due[best] = add_sat48(tm_now, {16'd0, tm_ivl[best]});
      else tm_vld[best] = 1'b0;
    end
    return n;
  endfunction

  function automatic void predict_request(op_t op, logic [47:0] w, logic [31:0] p,
                                          logic [31:0] t);
    int n0;
    bit hit;
    n0 = pending_results.size();
    case (op)
      OP_REL: add_timer(add_sat48(tm_now, w), '0);
      OP_ABS: add_timer(w, '0);
      OP_PER: begin
        if (w == 0) w = {16'd0, p};
        add_timer(add_sat48(tm_now, w), p);
      end
      OP_CANCEL: begin
        hit = 1'b0;
        for (int i = 0; i < QueueDepth; i++)
          if (tm_vld[i] && tm_id[i] == t) begin
            tm_cnc[i] = 1'b1;
            hit = 1'b1;
          end
        push_result(KIND_CANCEL, t, hit);
      end
      OP_PAUSE:  tm_paused = 1'b1;
      OP_RESUME: tm_paused = 1'b0;
      OP_CLEAR: begin
        for (int i = 0; i < QueueDepth; i++) begin
          tm_vld[i] = 1'b0;
          tm_cnc[i] = 1'b0;
          tm_due[i] = '0;
          tm_ivl[i] = '0;
          tm_id[i] = '0;
        end
      end
      default: void'(advance_tick());
    endcase
    if (pending_results.size() > n0)
      pending_results[pending_results.size() - 1].last = 1'b1;
    if (cur_row.typed) begin
      if (pending_results.size() == n0) begin
        $error("typed row: no result predicted");
        failed = 1'b1;
      end else if (pending_results[n0].kind != cur_row.kind ||
                   pending_results[n0].timer_id != cur_row.timer_id ||
                   pending_results[n0].found != cur_row.found) begin
        $error("typed row: predictor gives kind %0d id %0d found %0d",
               pending_results[n0].kind, pending_results[n0].timer_id,
               pending_results[n0].found);
        failed = 1'b1;
      end
    end
  endfunction

  // compare first, then predict, so one edge never races itself
  always @(posedge clk) begin
    timer_result_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d id %0d", out_ch.kind, out_ch.timer_id);
          failed = 1'b1;
        end else begin
          e = pending_results.pop_front();
          if (out_ch.kind != e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_ch.kind);
            failed = 1'b1;
          end
          if (out_ch.timer_id != e.timer_id) begin
            $error("timer_id: expected %0d, got %0d", e.timer_id, out_ch.timer_id);
            failed = 1'b1;
          end
          if (out_ch.found != e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_ch.found);
            failed = 1'b1;
          end
          if (out_ch.last != e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_ch.last);
            failed = 1'b1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_request(op_t'(in_ch.op), in_ch.when_value, in_ch.period, in_ch.target_id);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk)
    out_ch.ready = rst_n && ($urandom_range(99) >= stall_pct);

  task automatic send_request(stim_row_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    cur_row = r;
    in_ch.valid = 1'b1;
    in_ch.op = r.op;
    in_ch.when_value = r.when_value;
    in_ch.period = r.period;
    in_ch.target_id = r.target_id;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic stim_row_t row(op_t op, logic [47:0] w = '0, logic [31:0] p = '0,
                                    logic [31:0] t = '0);
    stim_row_t r;
    r.op = op;
    r.when_value = w;
    r.period = p;
    r.target_id = t;
    r.typed = 1'b0;
    r.kind = KIND_ID;
    r.timer_id = '0;
    r.found = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(stim_row_t r, kind_t k, logic [31:0] id,
                                          logic f);
    r.typed = 1'b1;
    r.kind = k;
    r.timer_id = id;
    r.found = f;
    return r;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int unsigned pick;
    r = row(OP_TICK);
    pick = $urandom_range(99);
    if (tm_paused && pick < 40) r.op = OP_RESUME;
    else if (pick < 30) r.op = op_t'($urandom_range(2));
    else if (pick < 42) r.op = OP_CANCEL;
    else if (pick < 45) r.op = OP_PAUSE;
    else if (pick < 48) r.op = OP_RESUME;
    else if (pick < 50) r.op = OP_CLEAR;
    if ($urandom_range(9) == 0) r.when_value = 48'({$urandom, $urandom});
    else if (r.op == OP_ABS) r.when_value = tm_now + 48'($urandom_range(6));
    else r.when_value = 48'($urandom_range(8));
    r.period = ($urandom_range(4) == 0) ? $urandom : $urandom_range(5);
    r.target_id = ($urandom_range(9) == 0) ? $urandom : tm_next_id - $urandom_range(1, 20);
    return r;
  endfunction

  initial begin
    failed = 1'b0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    cur_row = row(OP_TICK);
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_TICK;
    in_ch.when_value = '0;
    in_ch.period = '0;
    in_ch.target_id = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      tm_due[i] = '0;
      tm_ivl[i] = '0;
      tm_id[i] = '0;
      tm_vld[i] = 1'b0;
      tm_cnc[i] = 1'b0;
    end
    tm_now = '0;
    tm_next_id = 32'd1;
    tm_paused = 1'b0;

    add_row(row(OP_TICK));
    add_row(typed_row(row(OP_REL), KIND_ID, 32'd1, 1'b0));
    add_row(row(OP_TICK));
    add_row(row(OP_ABS, {48{1'b1}}));
    add_row(row(OP_PER, '0, 32'd2));           // zero first delay
    add_row(row(OP_PER, 48'd1, '0));           // one-shot periodic
    add_row(row(OP_REL, {48{1'b1}}));          // due saturates
    add_row(typed_row(row(OP_CANCEL, '0, '0, 32'd2), KIND_CANCEL, 32'd2, 1'b1));
    add_row(typed_row(row(OP_CANCEL, '0, '0, 32'd2), KIND_CANCEL, 32'd2, 1'b1));
    add_row(typed_row(row(OP_CANCEL, '0, '0, '1), KIND_CANCEL, '1, 1'b0));
    add_row(row(OP_PAUSE));
    add_row(row(OP_TICK));
    add_row(row(OP_RESUME));
    add_row(row(OP_TICK));
    add_row(row(OP_TICK));
    add_row(row(OP_CLEAR));
    // fill the table with timers already due, then overflow it
    for (int i = 0; i < QueueDepth; i++)
      add_row(row(OP_ABS, 48'd1, '1));
    add_row(typed_row(row(OP_REL, 48'd3), KIND_FULL, '0, 1'b0));
    add_row(row(OP_TICK));

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) send_request(rows[i]);

    for (int i = 0; i < RandItems; i++) begin
      case (i / (RandItems / 4))
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      send_request(random_row());
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed && pending_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
